// File: rtl/core/peu_pkg.sv
// Shared types, constants and fixed-point helpers for the particle Euler step.
// Used by particle_euler_update_core; no dependencies.
package peu_pkg;

    // Particle kinds carried in the mode field
    localparam logic [1:0] MODE_SPARK = 2'd0;
    localparam logic [1:0] MODE_EMBER = 2'd1;
    localparam logic [1:0] MODE_STEAM = 2'd2;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_SPARK_GRAVITY     = 3'd0,
        CFG_SPARK_RESTITUTION = 3'd1,
        CFG_SPARK_FRICTION    = 3'd2,
        CFG_EMBER_BUOYANCY    = 3'd3,
        CFG_EMBER_SHIMMER     = 3'd4,
        CFG_STEAM_BUOYANCY    = 3'd5,
        CFG_STEAM_GROWTH      = 3'd6
    } peu_cfg_t;

    localparam int NSTG = 10;

    // Radians (Q.12) to turns (Q0.44): 2^32 / (2*pi) scaled
    localparam logic [29:0] TURNS_PER_RAD = 30'd683565276;
    // Correction for a negative phase: low 12 bits of the constant placed at bit 32
    localparam logic [43:0] TURN_NEG_FIX  = {TURNS_PER_RAD[11:0], 32'd0};
    localparam logic [43:0] QUARTER_TURN  = 44'd4398046511104;

    localparam logic signed [31:0] POS_MAX = 32'sd8388607;
    localparam logic signed [31:0] POS_MIN = -32'sd8388608;
    localparam logic signed [31:0] U20_MAX = 32'sd1048575;

    typedef struct packed {
        logic [1:0]  mode;
        logic        alive;
        logic [19:0] life;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [23:0] pos_z;
        logic [23:0] vel_x;
        logic [23:0] vel_y;
        logic [23:0] vel_z;
        logic [19:0] size;
        logic [15:0] dt;
    } peu_item_t;

    // Shift right by 16, round to nearest, ties up
    function automatic logic signed [31:0] rnd16(input logic signed [47:0] p);
        logic signed [47:0] t;
        t = p + 48'sd32768;
        return 32'(t >>> 16);
    endfunction

    // Shift right by 30, round to nearest, ties up
    function automatic logic signed [31:0] rnd30(input logic signed [55:0] p);
        logic signed [55:0] t;
        t = p + 56'sd536870912;
        return 32'(t >>> 30);
    endfunction

    function automatic logic [23:0] sat24(input logic signed [31:0] v);
        if (v > POS_MAX)
            return POS_MAX[23:0];
        else if (v < POS_MIN)
            return POS_MIN[23:0];
        else
            return v[23:0];
    endfunction

    function automatic logic [19:0] satu20(input logic signed [31:0] v);
        if (v > U20_MAX)
            return U20_MAX[19:0];
        else if (v < 32'sd0)
            return 20'd0;
        else
            return v[19:0];
    endfunction

endpackage

// File: rtl/core/particle_euler_update_core.sv
// Top level of the particle Euler step: config registers, ten-stage datapath.
// Depends on peu_pkg and peu_sine_rom.
//
// One particle goes in per item and one updated particle comes out per item,
// in order. The datapath is a ten-stage pipeline: a new item can be taken in
// every clock cycle while the output side does not stall. Each stage holds
// its own valid bit, so a stall at the output only backs up as far as the
// first empty stage; the input stays ready while any stage downstream has
// room, including while a finished result waits in the output register.
// Sustained rate: one item per cycle while the output does not stall, set
// by the registered sine table read (two lookups per item) and one
// multiplier level per stage. Stage plan: 0 life and acceleration products,
// 1 vertical velocity, size and shimmer phases, 2 phase-to-turn products and
// steam keep products, 3 turn fix-up and keep rounding, 4 table index, 5 table
// read, 6 shimmer products, 7 shimmer add, 8 velocity*dt and bounce products,
// 9 position update, bounce and expiry (output register). Configuration writes
// take effect in the next cycle and should only be made while the pipeline is
// empty. Results saturate to the field ranges; an expired particle comes out
// with alive low and every other field zero.
module particle_euler_update_core import peu_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x[23:0] pos_y[47:24] pos_z[71:48] vel_x[95:72] vel_y[119:96] vel_z[143:120]
    // life_left[163:144] particle_size[183:164] dt[199:184] time_now[227:200]
    // steam_keep[244:228], zero fill [247:245]
    input  logic [247:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]   s_tuser,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_pos_x[23:0] new_pos_y[47:24] new_pos_z[71:48] new_vel_x[95:72]
    // new_vel_y[119:96] new_vel_z[143:120] new_life[163:144] new_size[183:164]
    output logic [183:0] m_tdata,
    // alive[0]
    output logic [0:0]   m_tuser,
    // configuration
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [19:0]  cfg_wdata
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [19:0]        gravity_reg;
    logic [16:0]        restitution_reg;
    logic [16:0]        friction_reg;
    logic signed [19:0] ember_buoy_reg;
    logic [19:0]        shimmer_reg;
    logic signed [19:0] steam_buoy_reg;
    logic signed [19:0] growth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg     <= 20'd40141;
            restitution_reg <= 17'd26214;
            friction_reg    <= 17'd45875;
            ember_buoy_reg  <= '0;
            shimmer_reg     <= '0;
            steam_buoy_reg  <= '0;
            growth_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SPARK_GRAVITY:     gravity_reg     <= cfg_wdata;
                CFG_SPARK_RESTITUTION: restitution_reg <= cfg_wdata[16:0];
                CFG_SPARK_FRICTION:    friction_reg    <= cfg_wdata[16:0];
                CFG_EMBER_BUOYANCY:    ember_buoy_reg  <= cfg_wdata;
                CFG_EMBER_SHIMMER:     shimmer_reg     <= cfg_wdata;
                CFG_STEAM_BUOYANCY:    steam_buoy_reg  <= cfg_wdata;
                CFG_STEAM_GROWTH:      growth_reg      <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and backpressure: a stage loads when it is empty
    // or when its contents move on.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] rdy;

    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (rdy[0])
                vld_reg[0] <= s_tvalid;
            for (int k = 1; k < NSTG; k++)
                if (rdy[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign s_tready = rdy[0];

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    peu_item_t item_reg  [NSTG];
    peu_item_t item_next [NSTG];

    logic signed [37:0] s0_prod_a_reg, s0_prod_a_next;
    logic signed [36:0] s0_prod_g_reg, s0_prod_g_next;
    logic [35:0]        s0_amp_reg,    s0_amp_next;
    logic [29:0]        s0_t3_reg,     s0_t3_next;
    logic [39:0]        s0_t2355_reg,  s0_t2355_next;
    logic signed [24:0] s0_d_reg,      s0_d_next;
    logic [16:0]        s0_keep_reg;

    logic [31:0]        s1_ph_s_reg, s1_ph_s_next;
    logic [31:0]        s1_ph_c_reg, s1_ph_c_next;
    logic [35:0]        s1_amp_reg;
    logic [16:0]        s1_keep_reg;

    logic [43:0]        s2_fs_reg, s2_fc_reg;
    logic [61:0]        s2_fs_full, s2_fc_full;
    logic               s2_ns_reg, s2_nc_reg;
    logic signed [41:0] s2_kx_reg, s2_kx_next;
    logic signed [41:0] s2_ky_reg, s2_ky_next;
    logic signed [41:0] s2_kz_reg, s2_kz_next;
    logic [35:0]        s2_amp_reg;

    logic [43:0]        s3_frac_s_reg, s3_frac_s_next;
    logic [43:0]        s3_frac_c_reg, s3_frac_c_next;
    logic [35:0]        s3_amp_reg;

    logic [56:0]        s4_ps, s4_pc;
    logic [IDX_W-1:0]   s4_idx_s_reg, s4_idx_c_reg;
    logic [35:0]        s4_amp_reg;

    logic signed [15:0] s5_sin, s5_cos;
    logic [35:0]        s5_amp_reg;

    logic signed [52:0] s6_shx_reg, s6_shx_next;
    logic signed [52:0] s6_shz_reg, s6_shz_next;

    logic signed [40:0] s8_dx_reg, s8_dx_next;
    logic signed [40:0] s8_dy_reg, s8_dy_next;
    logic signed [40:0] s8_dz_reg, s8_dz_next;
    logic signed [41:0] s8_bx_reg, s8_bx_next;
    logic signed [42:0] s8_by_reg, s8_by_next;
    logic signed [41:0] s8_bz_reg, s8_bz_next;

    // ------------------------------------------------------------------
    // Stage 0: unpack, life difference, acceleration and phase products
    // ------------------------------------------------------------------
    logic [27:0]        in_time;
    logic [16:0]        in_keep;
    logic signed [20:0] s0_accel;
    logic signed [16:0] s0_dt_s;

    assign in_time = s_tdata[227:200];
    assign in_keep = s_tdata[244:228];

    always_comb
    begin
        item_next[0].mode  = s_tuser;
        item_next[0].alive = 1'b0;
        item_next[0].life  = s_tdata[163:144];
        item_next[0].pos_x = s_tdata[23:0];
        item_next[0].pos_y = s_tdata[47:24];
        item_next[0].pos_z = s_tdata[71:48];
        item_next[0].vel_x = s_tdata[95:72];
        item_next[0].vel_y = s_tdata[119:96];
        item_next[0].vel_z = s_tdata[143:120];
        item_next[0].size  = s_tdata[183:164];
        item_next[0].dt    = s_tdata[199:184];

        s0_dt_s = $signed({1'b0, item_next[0].dt});
        // sparks fall: their gravity is subtracted later, so keep it positive here
        if (s_tuser == MODE_SPARK)
            s0_accel = $signed({1'b0, gravity_reg});
        else if (s_tuser == MODE_EMBER)
            s0_accel = 21'(ember_buoy_reg);
        else
            s0_accel = 21'(steam_buoy_reg);

        s0_prod_a_next = s0_accel * s0_dt_s;
        s0_prod_g_next = growth_reg * s0_dt_s;
        s0_amp_next    = shimmer_reg * item_next[0].dt;
        s0_t3_next     = 30'(in_time) * 30'd3;
        s0_t2355_next  = 40'(in_time) * 40'd2355;
        s0_d_next      = $signed({1'b0, item_next[0].life, 4'd0})
                       - $signed({9'd0, item_next[0].dt});
    end

    // ------------------------------------------------------------------
    // Stage 1: life, vertical velocity, steam size, shimmer phases
    // ------------------------------------------------------------------
    logic signed [31:0] s1_dy;
    logic signed [31:0] s1_vy;
    logic signed [24:0] s1_dr;

    always_comb
    begin
        item_next[1] = item_reg[0];
        s1_dr        = s0_d_reg + 25'sd15;
        item_next[1].alive = (s0_d_reg > 25'sd0);
        item_next[1].life  = s1_dr[23:4];

        s1_dy = rnd16(48'(s0_prod_a_reg));
        s1_vy = 32'($signed(item_reg[0].vel_y));
        unique case (item_reg[0].mode)
            MODE_SPARK: item_next[1].vel_y = sat24(s1_vy - s1_dy);
            MODE_EMBER: item_next[1].vel_y = sat24(s1_vy + s1_dy);
            MODE_STEAM:
            begin
                item_next[1].vel_y = sat24(s1_vy + s1_dy);
                item_next[1].size  = satu20(32'($signed({1'b0, item_reg[0].size}))
                                            + rnd16(48'(s0_prod_g_reg)));
            end
            default:
            begin
            end
        endcase

        // phases in Q.12 radians from the old position
        s1_ph_s_next = 32'($signed({2'b0, s0_t3_reg}))
                     + (32'($signed(item_reg[0].pos_y)) <<< 3);
        s1_ph_c_next = 32'($signed({2'b0, s0_t2355_reg[39:10]}))
                     + (32'($signed(item_reg[0].pos_x)) <<< 3);
    end

    // ------------------------------------------------------------------
    // Stage 2: phase to turn fraction (low bits only), steam keep products
    // ------------------------------------------------------------------
    always_comb
    begin
        item_next[2] = item_reg[1];
        s2_fs_full   = s1_ph_s_reg * TURNS_PER_RAD;
        s2_fc_full   = s1_ph_c_reg * TURNS_PER_RAD;
        s2_kx_next   = $signed(item_reg[1].vel_x) * $signed({1'b0, s1_keep_reg});
        s2_ky_next   = $signed(item_reg[1].vel_y) * $signed({1'b0, s1_keep_reg});
        s2_kz_next   = $signed(item_reg[1].vel_z) * $signed({1'b0, s1_keep_reg});
    end

    // ------------------------------------------------------------------
    // Stage 3: sign fix-up of the turn fraction, quarter turn for cosine,
    // steam velocity rounding
    // ------------------------------------------------------------------
    always_comb
    begin
        item_next[3]   = item_reg[2];
        s3_frac_s_next = s2_fs_reg - (s2_ns_reg ? TURN_NEG_FIX : 44'd0);
        s3_frac_c_next = s2_fc_reg - (s2_nc_reg ? TURN_NEG_FIX : 44'd0) + QUARTER_TURN;
        if (item_reg[2].mode == MODE_STEAM)
        begin
            item_next[3].vel_x = sat24(rnd16(48'(s2_kx_reg)));
            item_next[3].vel_y = sat24(rnd16(48'(s2_ky_reg)));
            item_next[3].vel_z = sat24(rnd16(48'(s2_kz_reg)));
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: table index = floor(frac * depth)
    // ------------------------------------------------------------------
    assign s4_ps = 57'(s3_frac_s_reg) * 57'(SINE_TABLE_DEPTH);
    assign s4_pc = 57'(s3_frac_c_reg) * 57'(SINE_TABLE_DEPTH);

    always_comb
    begin
        item_next[4] = item_reg[3];
    end

    // ------------------------------------------------------------------
    // Stage 5: table read (registered inside the ROM)
    // ------------------------------------------------------------------
    peu_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk     (clk),
        .en      (rdy[5]),
        .idx_s   (s4_idx_s_reg),
        .idx_c   (s4_idx_c_reg),
        .sin_val (s5_sin),
        .cos_val (s5_cos)
    );

    always_comb
    begin
        item_next[5] = item_reg[4];
    end

    // ------------------------------------------------------------------
    // Stage 6: shimmer products
    // ------------------------------------------------------------------
    always_comb
    begin
        item_next[6] = item_reg[5];
        s6_shx_next  = s5_sin * $signed({1'b0, s5_amp_reg});
        s6_shz_next  = s5_cos * $signed({1'b0, s5_amp_reg});
    end

    // ------------------------------------------------------------------
    // Stage 7: add shimmer to ember velocity
    // ------------------------------------------------------------------
    always_comb
    begin
        item_next[7] = item_reg[6];
        if (item_reg[6].mode == MODE_EMBER)
        begin
            item_next[7].vel_x = sat24(32'($signed(item_reg[6].vel_x))
                                       + rnd30(56'(s6_shx_reg)));
            item_next[7].vel_z = sat24(32'($signed(item_reg[6].vel_z))
                                       + rnd30(56'(s6_shz_reg)));
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: velocity*dt and spark bounce products (bounce taken or not
    // is settled in the next stage)
    // ------------------------------------------------------------------
    logic signed [16:0] s8_dt_s;
    logic signed [24:0] s8_nvy;

    always_comb
    begin
        item_next[8] = item_reg[7];
        s8_dt_s      = $signed({1'b0, item_reg[7].dt});
        s8_nvy       = -25'($signed(item_reg[7].vel_y));
        s8_dx_next   = $signed(item_reg[7].vel_x) * s8_dt_s;
        s8_dy_next   = $signed(item_reg[7].vel_y) * s8_dt_s;
        s8_dz_next   = $signed(item_reg[7].vel_z) * s8_dt_s;
        s8_by_next   = s8_nvy * $signed({1'b0, restitution_reg});
        s8_bx_next   = $signed(item_reg[7].vel_x) * $signed({1'b0, friction_reg});
        s8_bz_next   = $signed(item_reg[7].vel_z) * $signed({1'b0, friction_reg});
    end

    // ------------------------------------------------------------------
    // Stage 9: position update, ground bounce, expiry
    // ------------------------------------------------------------------
    logic [23:0] s9_py;

    always_comb
    begin
        item_next[9] = item_reg[8];
        s9_py        = sat24(32'($signed(item_reg[8].pos_y)) + rnd16(48'(s8_dy_reg)));
        if (item_reg[8].mode != 2'd3)
        begin
            item_next[9].pos_x = sat24(32'($signed(item_reg[8].pos_x))
                                       + rnd16(48'(s8_dx_reg)));
            item_next[9].pos_y = s9_py;
            item_next[9].pos_z = sat24(32'($signed(item_reg[8].pos_z))
                                       + rnd16(48'(s8_dz_reg)));
        end
        // spark below ground and still falling: clamp and bounce
        if (item_reg[8].mode == MODE_SPARK && s9_py[23] && item_reg[8].vel_y[23])
        begin
            item_next[9].pos_y = '0;
            item_next[9].vel_y = sat24(rnd16(48'(s8_by_reg)));
            item_next[9].vel_x = sat24(rnd16(48'(s8_bx_reg)));
            item_next[9].vel_z = sat24(rnd16(48'(s8_bz_reg)));
        end
        // expired: drop everything
        if (!item_reg[8].alive)
            item_next[9] = '0;
    end

    // ------------------------------------------------------------------
    // Payload registers (advance with their stage)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTG; k++)
            if (rdy[k])
                item_reg[k] <= item_next[k];

        if (rdy[0])
        begin
            s0_prod_a_reg <= s0_prod_a_next;
            s0_prod_g_reg <= s0_prod_g_next;
            s0_amp_reg    <= s0_amp_next;
            s0_t3_reg     <= s0_t3_next;
            s0_t2355_reg  <= s0_t2355_next;
            s0_d_reg      <= s0_d_next;
            s0_keep_reg   <= in_keep;
        end
        if (rdy[1])
        begin
            s1_ph_s_reg <= s1_ph_s_next;
            s1_ph_c_reg <= s1_ph_c_next;
            s1_amp_reg  <= s0_amp_reg;
            s1_keep_reg <= s0_keep_reg;
        end
        if (rdy[2])
        begin
            s2_fs_reg  <= s2_fs_full[43:0];
            s2_fc_reg  <= s2_fc_full[43:0];
            s2_ns_reg  <= s1_ph_s_reg[31];
            s2_nc_reg  <= s1_ph_c_reg[31];
            s2_kx_reg  <= s2_kx_next;
            s2_ky_reg  <= s2_ky_next;
            s2_kz_reg  <= s2_kz_next;
            s2_amp_reg <= s1_amp_reg;
        end
        if (rdy[3])
        begin
            s3_frac_s_reg <= s3_frac_s_next;
            s3_frac_c_reg <= s3_frac_c_next;
            s3_amp_reg    <= s2_amp_reg;
        end
        if (rdy[4])
        begin
            s4_idx_s_reg <= s4_ps[44 +: IDX_W];
            s4_idx_c_reg <= s4_pc[44 +: IDX_W];
            s4_amp_reg   <= s3_amp_reg;
        end
        if (rdy[5])
            s5_amp_reg <= s4_amp_reg;
        if (rdy[6])
        begin
            s6_shx_reg <= s6_shx_next;
            s6_shz_reg <= s6_shz_next;
        end
        if (rdy[8])
        begin
            s8_dx_reg <= s8_dx_next;
            s8_dy_reg <= s8_dy_next;
            s8_dz_reg <= s8_dz_next;
            s8_bx_reg <= s8_bx_next;
            s8_by_reg <= s8_by_next;
            s8_bz_reg <= s8_bz_next;
        end
    end

    // ------------------------------------------------------------------
    // Output
    // ------------------------------------------------------------------
    assign m_tvalid   = vld_reg[NSTG-1];
    assign m_tuser[0] = item_reg[NSTG-1].alive;
    assign m_tdata    = {item_reg[NSTG-1].size,  item_reg[NSTG-1].life,
                         item_reg[NSTG-1].vel_z, item_reg[NSTG-1].vel_y,
                         item_reg[NSTG-1].vel_x, item_reg[NSTG-1].pos_z,
                         item_reg[NSTG-1].pos_y, item_reg[NSTG-1].pos_x};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("expired particle carries nonzero fields");

    a_live_life: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[163:144] != 20'd0)
        else $error("live particle reports zero life");

    a_room_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[NSTG-1] |-> s_tready)
        else $error("input stalled while output stage is empty");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (32'(s4_idx_s_reg) < SINE_TABLE_DEPTH)
                    && (32'(s4_idx_c_reg) < SINE_TABLE_DEPTH))
        else $error("sine table index out of range");

endmodule

// File: rtl/core/peu_sine_rom.sv
// Sine table with two registered read ports (sine and cosine lookups).
// Table contents are computed at elaboration; no package dependency.
module peu_sine_rom #(
    parameter int DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [$clog2(DEPTH)-1:0]   idx_s,
    input  logic [$clog2(DEPTH)-1:0]   idx_c,
    output logic signed [15:0]         sin_val,
    output logic signed [15:0]         cos_val
);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // sin(2*pi*i/DEPTH) in Q1.14, odd degree-9 polynomial over a quarter wave
    function automatic logic signed [15:0] sine_entry(input int i);
        logic [63:0] p;
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        p    = (64'(i) << 32) / DEPTH;
        quad = p[31:30];
        r    = p & (ONE_Q30 - 64'd1);
        if (quad[0])
            r = ONE_Q30 - r;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + 64'd32768) >> 16;
        return quad[1] ? -16'(s) : 16'(s);
    endfunction

    logic signed [15:0] rom [DEPTH];

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_rom
        assign rom[gi] = sine_entry(gi);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_val <= rom[idx_s];
            cos_val <= rom[idx_c];
        end
    end

endmodule
